>>> hw/rtl/nbr_pkg.sv
package nbr_pkg;

  // item kinds on the input channel
  typedef enum logic {
    OP_LOAD     = 1'b0,
    OP_CLASSIFY = 1'b1
  } opcode_t;

  localparam int SLOT_W   = 3;
  localparam int INDEX_W  = 3;
  localparam int DIST_W   = 26;
  localparam int ACTIVE_W = 4;
  localparam int AXES     = 3;
  localparam int COORDS   = 6;

  // control into the root unit
  typedef struct packed {
    logic start;
  } sqrt_ctrl_t;

  // status back from the root unit
  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

>>> hw/rtl/nbr_sqrt.sv
module nbr_sqrt #(
  parameter int RAD_W = 52
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  nbr_pkg::sqrt_ctrl_t   ctrl,
  input  logic [RAD_W-1:0]      radicand,
  output nbr_pkg::sqrt_stat_t   stat,
  output logic [RAD_W/2-1:0]    root
);
  import nbr_pkg::*;

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 3;
  localparam int CNT_W  = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [REM_W-1:0]  trial;

  // trial subtract of one root digit, two radicand bits a step
  assign trial = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]} - {1'b0, root_r, 2'b01};

  // digit recurrence, one root bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start && !busy_r) begin
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CNT_W'(ROOT_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rad_r <= rad_r << 2;
        if (!trial[REM_W-1]) begin
          rem_r  <= trial;
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r;

  // done is a single pulse at the end of a run
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("root done without a run");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("root done held");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.start && !busy_r) |=> (busy_r && cnt_r == CNT_W'(ROOT_W)))
    else $error("root run did not start");

endmodule

>>> hw/rtl/nearest_box_representative.sv
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_stall    | opcode, slot, min and max corners
// out     | output    | out_valid / out_stall  | nearest_index, nearest_distance
// cfg     | input     | cfg_we                 | active_clusters
//
// a load item is written to its slot when taken; a classify item walks the K active slots, two corners each;
// K is the active slot count, and the root width is 26 at 24-bit coordinates
// the shared root unit gives one bit per cycle; one multiplier serves all axes
// reset is synchronous, active low; the slot memory is not cleared
// no new item is taken until the result of a classify item has been taken on out
module nearest_box_representative #(
  parameter int MAX_CLUSTERS = 8,
  parameter int COORD_BITS   = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [nbr_pkg::ACTIVE_W-1:0]      cfg_active_clusters,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_opcode,
  input  logic [nbr_pkg::SLOT_W-1:0]        in_slot,
  input  logic signed [COORD_BITS-1:0]      in_min_x,
  input  logic signed [COORD_BITS-1:0]      in_min_y,
  input  logic signed [COORD_BITS-1:0]      in_min_z,
  input  logic signed [COORD_BITS-1:0]      in_max_x,
  input  logic signed [COORD_BITS-1:0]      in_max_y,
  input  logic signed [COORD_BITS-1:0]      in_max_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [nbr_pkg::INDEX_W-1:0]       out_nearest_index,
  output logic [nbr_pkg::DIST_W-1:0]        out_nearest_distance
);
  import nbr_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int MAG_W  = C + 1;
  localparam int SQ_W   = 2 * C + 2;
  localparam int ACC_W  = 2 * C + 4;
  localparam int RAD_W  = (ACC_W > 64) ? 64 : ACC_W;
  localparam int ROOT_W = RAD_W / 2;
  localparam int DSUM_W = ROOT_W + 1;
  localparam int CMP_W  = (DSUM_W > DIST_W) ? DSUM_W : DIST_W;
  localparam int IDX_W  = $clog2(MAX_CLUSTERS);
  localparam int CNT_W  = $clog2(MAX_CLUSTERS + 1);
  localparam int KW     = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;
  localparam int SXW    = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;
  localparam int OXW    = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
  localparam int ENT_W  = COORDS * C;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_DIFF, S_MUL, S_ACC, S_SQST, S_ROOT, S_OUT
  } state_t;

  state_t               state_r;
  logic [ACTIVE_W-1:0]  active_r;
  logic [CNT_W-1:0]     kmax_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [1:0]           axis_r;
  logic                 corner_r;
  logic signed [C-1:0]  box_r [COORDS];
  logic [MAG_W-1:0]     mag_r;
  logic [SQ_W-1:0]      prod_r;
  logic [ACC_W-1:0]     acc_r;
  logic [ROOT_W-1:0]    root0_r;
  logic [DSUM_W-1:0]    best_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic                 out_valid_r;
  logic [DIST_W-1:0]    out_dist_r;
  logic [INDEX_W-1:0]   out_idx_r;

  logic [ENT_W-1:0]     mem [MAX_CLUSTERS];
  logic [ENT_W-1:0]     rd_r;

  logic                 accept;
  logic [SXW-1:0]       slot_ext;
  logic [KW-1:0]        act_ext;
  logic [CNT_W-1:0]     kmax_nxt;
  logic [2:0]           coord_sel;
  logic signed [C-1:0]  box_c;
  logic signed [C-1:0]  rep_c;
  logic signed [MAG_W-1:0] diff;
  logic [MAG_W-1:0]     mag_nxt;
  logic [RAD_W-1:0]     radicand;
  logic [ROOT_W-1:0]    root;
  logic [DSUM_W-1:0]    dsum;
  logic [CMP_W-1:0]     dsum_ext;
  logic [OXW-1:0]       idx_ext;
  sqrt_ctrl_t           sq_ctrl;
  sqrt_stat_t           sq_stat;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign slot_ext = SXW'(in_slot);
  assign act_ext  = KW'(active_r);

  // clamp the active slot count to one .. MAX_CLUSTERS
  always_comb begin
    if (act_ext == '0) begin
      kmax_nxt = CNT_W'(1);
    end else if (act_ext > KW'(MAX_CLUSTERS)) begin
      kmax_nxt = CNT_W'(MAX_CLUSTERS);
    end else begin
      kmax_nxt = CNT_W'(act_ext);
    end
  end

  // coordinate pair for the current corner and axis
  assign coord_sel = corner_r ? 3'(AXES) + 3'(axis_r) : 3'(axis_r);
  assign box_c     = box_r[coord_sel];
  assign rep_c     = rd_r[coord_sel * C +: C];
  assign diff      = $signed({box_c[C-1], box_c}) - $signed({rep_c[C-1], rep_c});
  assign mag_nxt   = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

  // squared length saturates where it cannot fit the root unit
  generate
    if (ACC_W > RAD_W) begin : g_sat
      assign radicand = (|acc_r[ACC_W-1:RAD_W]) ? '1 : acc_r[RAD_W-1:0];
    end else begin : g_nosat
      assign radicand = acc_r[RAD_W-1:0];
    end
  endgenerate

  assign sq_ctrl.start = (state_r == S_SQST);

  nbr_sqrt #(
    .RAD_W (RAD_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (sq_ctrl),
    .radicand (radicand),
    .stat     (sq_stat),
    .root     (root)
  );

  assign dsum     = DSUM_W'(root0_r) + DSUM_W'(root);
  assign dsum_ext = CMP_W'(best_r);
  assign idx_ext  = OXW'(best_idx_r);

  // representative store, one write port and one registered read
  always_ff @(posedge clk) begin
    if (accept && in_opcode == OP_LOAD && slot_ext < SXW'(MAX_CLUSTERS)) begin
      mem[slot_ext[IDX_W-1:0]] <= {in_max_z, in_max_y, in_max_x, in_min_z, in_min_y, in_min_x};
    end
    rd_r <= mem[cnt_r[IDX_W-1:0]];
  end

  // sequencer: slots one after another, two corners each, three axes each
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= ACTIVE_W'(8);
      kmax_r      <= CNT_W'(1);
      cnt_r       <= '0;
      axis_r      <= '0;
      corner_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        active_r <= cfg_active_clusters;
      end
      case (state_r)
        S_IDLE: begin
          if (accept && in_opcode == OP_CLASSIFY) begin
            box_r[0] <= in_min_x;
            box_r[1] <= in_min_y;
            box_r[2] <= in_min_z;
            box_r[3] <= in_max_x;
            box_r[4] <= in_max_y;
            box_r[5] <= in_max_z;
            kmax_r   <= kmax_nxt;
            cnt_r    <= '0;
            state_r  <= S_READ;
          end
        end
        S_READ: begin
          axis_r   <= '0;
          corner_r <= 1'b0;
          acc_r    <= '0;
          state_r  <= S_DIFF;
        end
        S_DIFF: begin
          mag_r   <= mag_nxt;
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= mag_r * mag_r;
          state_r <= S_ACC;
        end
        S_ACC: begin
          acc_r <= acc_r + ACC_W'(prod_r);
          if (axis_r == 2'(AXES - 1)) begin
            state_r <= S_SQST;
          end else begin
            axis_r  <= axis_r + 1'b1;
            state_r <= S_DIFF;
          end
        end
        S_SQST: begin
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          if (sq_stat.done) begin
            if (!corner_r) begin
              // min corner done, go on with the max corner
              root0_r  <= root;
              corner_r <= 1'b1;
              axis_r   <= '0;
              acc_r    <= '0;
              state_r  <= S_DIFF;
            end else begin
              // strict compare keeps the lowest index on ties
              if (cnt_r == '0 || dsum < best_r) begin
                best_r     <= dsum;
                best_idx_r <= cnt_r[IDX_W-1:0];
              end
              cnt_r <= cnt_r + 1'b1;
              if (cnt_r == kmax_r - 1'b1) begin
                state_r <= S_OUT;
              end else begin
                state_r <= S_READ;
              end
            end
          end
        end
        S_OUT: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= idx_ext[INDEX_W-1:0];
            out_dist_r  <= (dsum_ext > CMP_W'({DIST_W{1'b1}})) ?
                           {DIST_W{1'b1}} : dsum_ext[DIST_W-1:0];
          end else if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_nearest_index    = out_idx_r;
  assign out_nearest_distance = out_dist_r;

  // no new item while a result waits
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("item taken while result pending");
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (cnt_r < kmax_r)) else $error("slot walk overran");
  a_kmax_range: assert property (@(posedge clk) disable iff (!rst_n)
    (kmax_r >= CNT_W'(1)) && (kmax_r <= CNT_W'(MAX_CLUSTERS)))
    else $error("active count out of range");
  a_root_state: assert property (@(posedge clk) disable iff (!rst_n)
    sq_stat.done |-> (state_r == S_ROOT)) else $error("root result not awaited");

endmodule

>>> dv/tb_nearest_box_representative.sv
module tb_nearest_box_representative;
  timeunit 1ns;
  timeprecision 1ps;
  import nbr_pkg::*;

  localparam int SLOTS     = 8;
  localparam int CW        = 24;
  localparam int SETTLE    = 40;
  localparam int MAX_CYCLES = 1500000;
  localparam logic [DIST_W-1:0] DIST_SAT = '1;

  typedef logic signed [CW-1:0] coords_t [COORDS];
  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [DIST_W-1:0]  distance;
  } nearest_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ACTIVE_W-1:0] cfg_active_clusters = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_opcode = 1'b0;
  logic [SLOT_W-1:0] in_slot = '0;
  logic signed [CW-1:0] in_min_x = '0, in_min_y = '0, in_min_z = '0;
  logic signed [CW-1:0] in_max_x = '0, in_max_y = '0, in_max_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [INDEX_W-1:0] out_nearest_index;
  logic [DIST_W-1:0] out_nearest_distance;

  nearest_box_representative #(.MAX_CLUSTERS(SLOTS), .COORD_BITS(CW)) dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_active_clusters(cfg_active_clusters),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode), .in_slot(in_slot),
    .in_min_x(in_min_x), .in_min_y(in_min_y), .in_min_z(in_min_z),
    .in_max_x(in_max_x), .in_max_y(in_max_y), .in_max_z(in_max_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_nearest_index(out_nearest_index), .out_nearest_distance(out_nearest_distance)
  );

  // shadow copy of the block state
  coords_t rep_boxes [SLOTS];
  logic [ACTIVE_W-1:0] active_count = 4'd8;
  nearest_t pending_nearest[$];
  int mismatches = 0;
  int idle_max = 12;
  int cycle_count = 0;
  int stall_left = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // integer root, rounded down
  function automatic logic [63:0] floor_root(logic [63:0] n);
    logic [63:0] root, probe;
    root = '0;
    probe = 64'd1 << 62;
    while (probe > n) probe = probe >> 2;
    while (probe != 0) begin
      if (n >= root + probe) begin
        n = n - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] corner_dist(coords_t a, coords_t b, int base);
    logic [63:0] acc;
    longint diff;
    acc = '0;
    for (int i = base; i < base + AXES; i++) begin
      diff = longint'(a[i]) - longint'(b[i]);
      acc = acc + 64'(diff * diff);
    end
    return floor_root(acc);
  endfunction

  function automatic nearest_t nearest_of(coords_t box);
    int k;
    logic [63:0] best, d;
    nearest_t r;
    k = active_count;
    if (k < 1) k = 1;
    if (k > SLOTS) k = SLOTS;
    best = '0;
    r = '0;
    for (int c = 0; c < k; c++) begin
      d = corner_dist(box, rep_boxes[c], 0) + corner_dist(box, rep_boxes[c], AXES);
      if (c == 0 || d < best) begin
        best = d;
        r.index = INDEX_W'(c);
      end
    end
    r.distance = (best > 64'(DIST_SAT)) ? DIST_SAT : DIST_W'(best);
    return r;
  endfunction

  // result side: random stall and compare against oldest expectation
  always @(posedge clk) begin
    nearest_t exp_r;
    int draw;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      if (pending_nearest.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected result: index %0d distance %0d",
                   out_nearest_index, out_nearest_distance);
      end else begin
        exp_r = pending_nearest.pop_front();
        if (out_nearest_index !== exp_r.index || out_nearest_distance !== exp_r.distance) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected index %0d distance %0d, got index %0d distance %0d",
                     exp_r.index, exp_r.distance, out_nearest_index, out_nearest_distance);
        end
      end
      draw = $urandom_range(0, idle_max);
      stall_left <= draw;
      out_stall <= (draw != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end
  end

  // send one item and update the prediction when it is taken
  task automatic send_item(opcode_t op, logic [SLOT_W-1:0] slot, coords_t box);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_opcode <= op;
    in_slot <= slot;
    in_min_x <= box[0]; in_min_y <= box[1]; in_min_z <= box[2];
    in_max_x <= box[3]; in_max_y <= box[4]; in_max_z <= box[5];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (op == OP_LOAD) rep_boxes[slot] = box;
    else pending_nearest = {pending_nearest, nearest_of(box)};
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_nearest.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_active(logic [ACTIVE_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_active_clusters <= value;
    @(posedge clk);
    active_count = value;
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [CW-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return {1'b0, {(CW-1){1'b1}}};
      1: return {1'b1, {(CW-1){1'b0}}};
      2: return CW'($urandom_range(0, 2000)) - CW'(1000);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic coords_t random_box();
    coords_t b;
    for (int i = 0; i < COORDS; i++) b[i] = pick_coord();
    return b;
  endfunction

  // box near a stored representative, so nearest choice is meaningful
  function automatic coords_t near_box(int slot);
    coords_t b;
    for (int i = 0; i < COORDS; i++)
      b[i] = rep_boxes[slot][i] + CW'($urandom_range(0, 4096)) - CW'(2048);
    return b;
  endfunction

  function automatic coords_t fill_box(logic signed [CW-1:0] v);
    coords_t b;
    for (int i = 0; i < COORDS; i++) b[i] = v;
    return b;
  endfunction

  // fill every slot, extremes in the end slots
  task automatic test_load_slots();
    send_item(OP_LOAD, 3'd0, fill_box({1'b0, {(CW-1){1'b1}}}));
    for (int s = 1; s < SLOTS - 1; s++) send_item(OP_LOAD, SLOT_W'(s), random_box());
    send_item(OP_LOAD, 3'd7, fill_box({1'b1, {(CW-1){1'b0}}}));
  endtask

  // corner cases: extremes, exact match, ties, register extremes
  task automatic test_directed();
    coords_t twin;
    send_item(OP_CLASSIFY, 3'd0, fill_box({1'b0, {(CW-1){1'b1}}}));
    send_item(OP_CLASSIFY, 3'd5, fill_box({1'b1, {(CW-1){1'b0}}}));
    send_item(OP_CLASSIFY, 3'd7, fill_box('0));
    send_item(OP_CLASSIFY, 3'd2, rep_boxes[3]);
    twin = random_box();
    send_item(OP_LOAD, 3'd2, twin);
    send_item(OP_LOAD, 3'd5, twin);
    send_item(OP_CLASSIFY, 3'd0, twin);
    send_item(OP_CLASSIFY, 3'd0, near_box(5));
    set_active(4'd1);
    send_item(OP_CLASSIFY, 3'd0, fill_box({1'b1, {(CW-1){1'b0}}}));
    set_active(4'd0);
    send_item(OP_CLASSIFY, 3'd0, random_box());
    set_active(4'd15);
    send_item(OP_CLASSIFY, 3'd0, rep_boxes[7]);
  endtask

  // random traffic over several active counts
  task automatic test_random_phases();
    logic [ACTIVE_W-1:0] counts [8] = '{4'd8, 4'd1, 4'd3, 4'd15, 4'd0, 4'd6, 4'd2, 4'd8};
    int sel;
    for (int p = 0; p < 8; p++) begin
      set_active(counts[p]);
      idle_max = (p == 5) ? 0 : 12;
      repeat (62) begin
        sel = $urandom_range(0, 9);
        if (sel < 3) send_item(OP_LOAD, SLOT_W'($urandom_range(0, 7)),
                               ($urandom_range(0, 1) != 0) ? random_box()
                                                           : near_box($urandom_range(0, 7)));
        else if (sel < 8) send_item(OP_CLASSIFY, SLOT_W'($urandom),
                                    near_box($urandom_range(0, 7)));
        else send_item(OP_CLASSIFY, SLOT_W'($urandom), random_box());
      end
    end
    idle_max = 12;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_load_slots();
    test_directed();
    test_random_phases();
    drain();
    if (mismatches == 0 && pending_nearest.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
